// ===== rtl/command_frame_receiver_defines.svh =====
// Assertion macros shared by the command frame receiver RTL.
// Depends on nothing; included by files that carry concurrent checks.
`ifndef COMMAND_FRAME_RECEIVER_DEFINES_SVH
`define COMMAND_FRAME_RECEIVER_DEFINES_SVH
`ifndef SYNTHESIS
// same-cycle implication, disabled during reset
`define CFR_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("cfr check failed");
// next-cycle implication, disabled during reset
`define CFR_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("cfr check failed");
`else
`define CFR_ASSERT_NOW(label, clk, rst, ante, cons)
`define CFR_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// ===== rtl/cfr_pkg.sv =====
// Constants, register indexes and type decode for the command frame receiver.
// Depends on nothing; used by command_frame_receiver.
`timescale 1ns / 1ps
package cfr_pkg;

   localparam int BUFFER_BYTES_DEFAULT = 64;
   localparam int FRAME_OVERHEAD       = 7;

   // register reset values
   localparam logic [7:0] PREAMBLE1_RESET  = 8'hF0;
   localparam logic [7:0] PREAMBLE2_RESET  = 8'hCA;
   localparam logic [7:0] POSTAMBLE1_RESET = 8'h53;
   localparam logic [7:0] POSTAMBLE2_RESET = 8'h0F;

   // register indexes
   localparam logic [1:0] CSR_PREAMBLE1  = 2'd0;
   localparam logic [1:0] CSR_PREAMBLE2  = 2'd1;
   localparam logic [1:0] CSR_POSTAMBLE1 = 2'd2;
   localparam logic [1:0] CSR_POSTAMBLE2 = 2'd3;

   // command types
   localparam logic [7:0] TYPE_ENABLE    = 8'h10;
   localparam logic [7:0] TYPE_SET_SPEED = 8'h11;
   localparam logic [7:0] TYPE_GET_SPEED = 8'h12;

   // decoded classes
   localparam logic [1:0] CLASS_INVALID   = 2'd0;
   localparam logic [1:0] CLASS_ENABLE    = 2'd1;
   localparam logic [1:0] CLASS_SET_SPEED = 2'd2;
   localparam logic [1:0] CLASS_GET_SPEED = 2'd3;

   function automatic logic [1:0] classify(input logic [7:0] t);
      logic [1:0] c;
      c = CLASS_INVALID;
      if (t == TYPE_ENABLE) c = CLASS_ENABLE;
      else if (t == TYPE_SET_SPEED) c = CLASS_SET_SPEED;
      else if (t == TYPE_GET_SPEED) c = CLASS_GET_SPEED;
      return c;
   endfunction

endpackage

// ===== rtl/cfr_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing; holds the frame store of the receiver.
`timescale 1ns / 1ps
module cfr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/command_frame_receiver.sv =====
// Command frame receiver: byte stream deframer with additive checksum.
// Depends on cfr_pkg, cfr_ram and command_frame_receiver_defines.svh.
//
// Usage:
//  - req_ channel takes one received byte per request (req_rx_byte).
//  - rsp_ channel returns, for each good frame, a header item (is_data 0)
//    followed by one item per payload byte; rsp_last marks the final item.
//  - csr_ port writes the four marker registers; the user must write them
//    only while the block is idle; the block itself leaves this unchecked.
//  - Frame: preamble1, preamble2, type, length, data, checksum, postamble1,
//    postamble2. Bytes live in a circular store of BUFFER_BYTES entries in
//    one RAM; a resync moves the base pointer instead of copying bytes.
// Flow:
//  - An ordinary byte is written to the store and parsed before ready again.
//  - A resync scans the store for preamble1, then replays the bytes kept;
//    a request may drop the whole store one byte at a time.
//  - A postamble hit runs the checksum, then each item waits on rsp_ready.
//  - req_ready is low for the whole of a request's work, including output.
// Reset: synchronous; markers return to their defaults, the store empties.
// A stalled receiver simply holds rsp_valid and the item until rsp_ready.
`timescale 1ns / 1ps
`include "command_frame_receiver_defines.svh"
module command_frame_receiver #(
   parameter int BUFFER_BYTES = cfr_pkg::BUFFER_BYTES_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_rx_byte,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic       rsp_is_data,
   output logic [7:0] rsp_packet_type,
   output logic [1:0] rsp_type_class,
   output logic [5:0] rsp_payload_length,
   output logic [7:0] rsp_payload_byte,
   output logic       rsp_last,
   input  logic       csr_write,
   input  logic [1:0] csr_index,
   input  logic [7:0] csr_data
);

   localparam int AW = $clog2(BUFFER_BYTES);
   localparam int CW = $clog2(BUFFER_BYTES + 1);
   localparam int PW = CW + 1;
   localparam logic [CW-1:0] BUF_C = CW'(BUFFER_BYTES);
   localparam logic [PW-1:0] BUF_P = PW'(BUFFER_BYTES);
   localparam logic [CW-1:0] OVH_C = CW'(cfr_pkg::FRAME_OVERHEAD);

   typedef enum logic [3:0] {
      ST_IDLE, ST_NEXT, ST_PARSE, ST_RS_SCAN, ST_CK_LEN, ST_CK_SUM, ST_CK_CS,
      ST_EM_WAIT, ST_EM_DATA
   } state_type;

   typedef enum logic [1:0] {
      PH_PRE1, PH_PRE2, PH_POST1, PH_POST2
   } phase_type;

   state_type state_ff, state_in;
   phase_type phase_ff, phase_in;
   logic [CW-1:0] pos_ff, pos_in;
   logic [CW-1:0] fill_ff, fill_in;
   logic [AW-1:0] base_ff, base_in;
   logic [CW-1:0] off_ff, off_in;
   logic [CW-1:0] idx_ff, idx_in;
   logic [7:0]    rx_ff, rx_in;
   logic          consumed_ff, consumed_in;
   logic          resync_ff, resync_in;
   logic          use_rx_ff, use_rx_in;
   logic [7:0]    sum_ff, sum_in;
   logic [7:0]    len_ff, len_in;
   logic [7:0]    type_ff, type_in;
   logic [7:0]    k_ff, k_in;

   logic       rsp_valid_ff, rsp_valid_in;
   logic       rsp_is_data_ff, rsp_is_data_in;
   logic [7:0] rsp_byte_ff, rsp_byte_in;
   logic       rsp_last_ff, rsp_last_in;

   logic [7:0] pre1_ff, pre2_ff, post1_ff, post2_ff;

   // ram control
   logic          rd_en;
   logic [CW-1:0] rd_log;
   logic [AW-1:0] rd_addr;
   logic          wr_en;
   logic [AW-1:0] wr_addr;
   logic [7:0]    rd_data;
   logic [PW-1:0] rd_sum, wr_sum, base_sum;
   logic          rs_done;
   logic [CW-1:0] rs_off;
   logic [7:0]    cur_byte;

   // logical to physical store address
   always_comb begin
      rd_sum   = PW'(base_ff) + PW'(rd_log);
      wr_sum   = PW'(base_ff) + PW'(pos_ff);
      base_sum = PW'(base_ff) + PW'(rs_off);
      rd_addr  = (rd_sum >= BUF_P) ? AW'(rd_sum - BUF_P) : AW'(rd_sum);
      wr_addr  = (wr_sum >= BUF_P) ? AW'(wr_sum - BUF_P) : AW'(wr_sum);
   end

   assign cur_byte = use_rx_ff ? rx_ff : rd_data;

   cfr_ram #(
      .WIDTH (8),
      .DEPTH (BUFFER_BYTES)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (rx_ff),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // sequencer next-state logic
   always_comb begin
      state_in       = state_ff;
      phase_in       = phase_ff;
      pos_in         = pos_ff;
      fill_in        = fill_ff;
      base_in        = base_ff;
      off_in         = off_ff;
      idx_in         = idx_ff;
      rx_in          = rx_ff;
      consumed_in    = consumed_ff;
      resync_in      = resync_ff;
      use_rx_in      = use_rx_ff;
      sum_in         = sum_ff;
      len_in         = len_ff;
      type_in        = type_ff;
      k_in           = k_ff;
      rsp_valid_in   = rsp_valid_ff;
      rsp_is_data_in = rsp_is_data_ff;
      rsp_byte_in    = rsp_byte_ff;
      rsp_last_in    = rsp_last_ff;
      rd_en          = 1'b0;
      rd_log         = '0;
      wr_en          = 1'b0;
      rs_done        = 1'b0;
      rs_off         = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               rx_in       = req_rx_byte;
               consumed_in = 1'b0;
               resync_in   = 1'b0;
               state_in    = ST_NEXT;
            end
         end
         ST_NEXT: begin
            if (resync_ff) begin
               if (fill_ff <= CW'(1)) begin
                  rs_done = 1'b1;
                  rs_off  = fill_ff;
               end else begin
                  off_in   = CW'(1);
                  rd_en    = 1'b1;
                  rd_log   = CW'(1);
                  state_in = ST_RS_SCAN;
               end
            end else if (pos_ff < fill_ff) begin
               rd_en     = 1'b1;
               rd_log    = pos_ff;
               pos_in    = pos_ff + CW'(1);
               use_rx_in = 1'b0;
               state_in  = ST_PARSE;
            end else if (!consumed_ff) begin
               consumed_in = 1'b1;
               if (pos_ff >= BUF_C) begin
                  resync_in = 1'b1;
               end else begin
                  wr_en     = 1'b1;
                  pos_in    = pos_ff + CW'(1);
                  fill_in   = pos_ff + CW'(1);
                  use_rx_in = 1'b1;
                  state_in  = ST_PARSE;
               end
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_RS_SCAN: begin
            // rd_data holds the byte at logical off_ff
            if (rd_data == pre1_ff) begin
               rs_done = 1'b1;
               rs_off  = off_ff;
            end else if (off_ff + CW'(1) >= fill_ff) begin
               rs_done = 1'b1;
               rs_off  = fill_ff;
            end else begin
               off_in = off_ff + CW'(1);
               rd_en  = 1'b1;
               rd_log = off_ff + CW'(1);
            end
         end
         ST_PARSE: begin
            state_in = ST_NEXT;
            unique case (phase_ff)
               PH_PRE1: begin
                  if (cur_byte != pre1_ff) resync_in = 1'b1;
                  else phase_in = PH_PRE2;
               end
               PH_PRE2: begin
                  if (cur_byte != pre2_ff) resync_in = 1'b1;
                  else phase_in = PH_POST1;
               end
               PH_POST1: begin
                  phase_in = (cur_byte == post1_ff) ? PH_POST2 : PH_POST1;
               end
               PH_POST2: begin
                  if (cur_byte != post2_ff) begin
                     phase_in = (cur_byte == post1_ff) ? PH_POST2 : PH_POST1;
                  end else if (pos_ff >= OVH_C) begin
                     rd_en    = 1'b1;
                     rd_log   = CW'(3);
                     state_in = ST_CK_LEN;
                  end else begin
                     phase_in = PH_POST1;
                  end
               end
               default: ;
            endcase
            if (state_in == ST_NEXT && pos_ff >= BUF_C) resync_in = 1'b1;
         end
         ST_CK_LEN: begin
            len_in = rd_data;
            if ({1'b0, rd_data} != (9'(pos_ff) - 9'(cfr_pkg::FRAME_OVERHEAD))) begin
               phase_in  = PH_POST1;
               resync_in = (pos_ff >= BUF_C);
               state_in  = ST_NEXT;
            end else begin
               idx_in   = CW'(2);
               sum_in   = '0;
               rd_en    = 1'b1;
               rd_log   = CW'(2);
               state_in = ST_CK_SUM;
            end
         end
         ST_CK_SUM: begin
            // running sum over type, length and data
            sum_in = sum_ff + rd_data;
            if (idx_ff == CW'(2)) type_in = rd_data;
            rd_en = 1'b1;
            if (8'(idx_ff) == len_ff + 8'd3) begin
               rd_log   = pos_ff - CW'(3);
               state_in = ST_CK_CS;
            end else begin
               idx_in = idx_ff + CW'(1);
               rd_log = idx_ff + CW'(1);
            end
         end
         ST_CK_CS: begin
            if (rd_data == sum_ff) begin
               rsp_valid_in   = 1'b1;
               rsp_is_data_in = 1'b0;
               rsp_byte_in    = '0;
               rsp_last_in    = (len_ff == 8'd0);
               k_in           = '0;
               state_in       = ST_EM_WAIT;
            end else begin
               phase_in  = PH_POST1;
               resync_in = (pos_ff >= BUF_C);
               state_in  = ST_NEXT;
            end
         end
         ST_EM_WAIT: begin
            if (rsp_ready) begin
               rsp_valid_in = 1'b0;
               if (rsp_last_ff) begin
                  pos_in   = '0;
                  fill_in  = '0;
                  phase_in = PH_PRE1;
                  state_in = ST_IDLE;
               end else begin
                  k_in     = k_ff + 8'd1;
                  rd_en    = 1'b1;
                  rd_log   = CW'(k_ff + 8'd4);
                  state_in = ST_EM_DATA;
               end
            end
         end
         ST_EM_DATA: begin
            rsp_valid_in   = 1'b1;
            rsp_is_data_in = 1'b1;
            rsp_byte_in    = rd_data;
            rsp_last_in    = (k_ff == len_ff);
            state_in       = ST_EM_WAIT;
         end
         default: state_in = ST_IDLE;
      endcase

      // resync finish: move base past the dropped bytes and replay
      if (rs_done) begin
         base_in   = (base_sum >= BUF_P) ? AW'(base_sum - BUF_P) : AW'(base_sum);
         fill_in   = fill_ff - rs_off;
         pos_in    = '0;
         phase_in  = PH_PRE1;
         resync_in = 1'b0;
         state_in  = ST_NEXT;
      end
   end

   // state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         phase_ff     <= PH_PRE1;
         pos_ff       <= '0;
         fill_ff      <= '0;
         base_ff      <= '0;
         consumed_ff  <= 1'b0;
         resync_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
         pre1_ff      <= cfr_pkg::PREAMBLE1_RESET;
         pre2_ff      <= cfr_pkg::PREAMBLE2_RESET;
         post1_ff     <= cfr_pkg::POSTAMBLE1_RESET;
         post2_ff     <= cfr_pkg::POSTAMBLE2_RESET;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         pos_ff       <= pos_in;
         fill_ff      <= fill_in;
         base_ff      <= base_in;
         consumed_ff  <= consumed_in;
         resync_ff    <= resync_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write) begin
            unique case (csr_index)
               cfr_pkg::CSR_PREAMBLE1:  pre1_ff  <= csr_data;
               cfr_pkg::CSR_PREAMBLE2:  pre2_ff  <= csr_data;
               cfr_pkg::CSR_POSTAMBLE1: post1_ff <= csr_data;
               cfr_pkg::CSR_POSTAMBLE2: post2_ff <= csr_data;
               default: ;
            endcase
         end
      end
      off_ff         <= off_in;
      idx_ff         <= idx_in;
      rx_ff          <= rx_in;
      use_rx_ff      <= use_rx_in;
      sum_ff         <= sum_in;
      len_ff         <= len_in;
      type_ff        <= type_in;
      k_ff           <= k_in;
      rsp_is_data_ff <= rsp_is_data_in;
      rsp_byte_ff    <= rsp_byte_in;
      rsp_last_ff    <= rsp_last_in;
   end

   assign req_ready          = (state_ff == ST_IDLE);
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_is_data        = rsp_is_data_ff;
   assign rsp_packet_type    = type_ff;
   assign rsp_type_class     = cfr_pkg::classify(type_ff);
   assign rsp_payload_length = len_ff[5:0];
   assign rsp_payload_byte   = rsp_byte_ff;
   assign rsp_last           = rsp_last_ff;

   // checks
   `CFR_ASSERT_NOW(a_no_ready_while_rsp, clock, reset, rsp_valid_ff, !req_ready)
   `CFR_ASSERT_NOW(a_pos_within_fill, clock, reset, 1'b1, (pos_ff <= fill_ff) && (fill_ff <= BUF_C))
   `CFR_ASSERT_NEXT(a_busy_after_req, clock, reset, req_valid && req_ready, !req_ready)
   `CFR_ASSERT_NEXT(a_idle_after_last, clock, reset, rsp_valid && rsp_ready && rsp_last, req_ready && (fill_ff == '0))

endmodule
